### hdl/gtg_pkg.sv
// Shared types, widths and constants of the go-to-goal heading controller.
package gtg_pkg;

    localparam int POS_W      = 16;
    localparam int HEAD_W     = 15;
    localparam int SPEED_W    = 15;
    localparam int RATE_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // CORDIC datapath: vectors scaled by 2^14, angles in Q3.28.
    localparam int XY_W         = 34;
    localparam int Z_W          = 32;
    localparam int ATAN_ENTRIES = 24;
    localparam int VEC_SHIFT    = 14;

    localparam logic signed [Z_W-1:0] HALF_PI_Q28 = 32'sd421657428;
    localparam int BOUND_Q12 = 12861;
    localparam int WRAP_Q12  = 2 * BOUND_Q12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X       = 3'd0,
        REG_GOAL_Y       = 3'd1,
        REG_STEER_GAIN   = 3'd2,
        REG_STOP_RADIUS  = 3'd3,
        REG_CRUISE_SPEED = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    // Sideband that travels with each request through the rotation cells.
    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic                     zero;
        logic                     arrived;
    } t_side;

    // atan(2^-i) in Q3.28, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_q28(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 32'sd210828714;
            1:       v = 32'sd124459457;
            2:       v = 32'sd65760959;
            3:       v = 32'sd33381290;
            4:       v = 32'sd16755422;
            5:       v = 32'sd8385879;
            6:       v = 32'sd4193963;
            7:       v = 32'sd2097109;
            8:       v = 32'sd1048571;
            9:       v = 32'sd524287;
            10:      v = 32'sd262144;
            11:      v = 32'sd131072;
            12:      v = 32'sd65536;
            13:      v = 32'sd32768;
            14:      v = 32'sd16384;
            15:      v = 32'sd8192;
            16:      v = 32'sd4096;
            17:      v = 32'sd2048;
            18:      v = 32'sd1024;
            19:      v = 32'sd512;
            20:      v = 32'sd256;
            21:      v = 32'sd128;
            22:      v = 32'sd64;
            23:      v = 32'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### hdl/gtg_if.sv
// Handshake interfaces for the pose, command and configuration channels.
interface gtg_pose_if import gtg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pose_x;
    logic signed [POS_W-1:0]  pose_y;
    logic signed [HEAD_W-1:0] heading;

    modport source (output valid, pose_x, pose_y, heading, input ready);
    modport sink   (input valid, pose_x, pose_y, heading, output ready);
endinterface

interface gtg_cmd_if import gtg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [SPEED_W-1:0]       linear_speed;
    logic signed [RATE_W-1:0] angular_rate;
    logic                     arrived;

    modport source (output valid, linear_speed, angular_rate, arrived, input ready);
    modport sink   (input valid, linear_speed, angular_rate, arrived, output ready);
endinterface

interface gtg_cfg_if import gtg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/gtg_front.sv
// Front end: goal offset, squared distance, arrival test and quadrant pre-rotation.
module gtg_front import gtg_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  logic signed [POS_W-1:0]  i_pose_x,
    input  logic signed [POS_W-1:0]  i_pose_y,
    input  logic signed [HEAD_W-1:0] i_heading,
    input  logic signed [POS_W-1:0]  i_goal_x,
    input  logic signed [POS_W-1:0]  i_goal_y,
    input  logic [2*POS_W-1:0]       i_stop_r2,
    output logic                     o_valid,
    output t_cordic                  o_vec,
    output t_side                    o_side
);

    localparam int D_W  = POS_W + 1;
    localparam int SQ_W = 2 * POS_W + 1;

    logic [2:0]              r_valid;
    logic signed [D_W-1:0]   r_dx1, r_dy1, r_dx2, r_dy2;
    logic signed [HEAD_W-1:0] r_hd1, r_hd2;
    logic [SQ_W-1:0]         r_dxsq, r_dysq;
    t_cordic                 r_vec;
    t_side                   r_side;

    logic signed [2*D_W-1:0] w_dxsq, w_dysq;
    logic [SQ_W:0]           w_d2;
    logic signed [XY_W-1:0]  w_x, w_y;
    t_cordic                 n_vec;
    t_side                   n_side;

    assign w_dxsq = r_dx1 * r_dx1;
    assign w_dysq = r_dy1 * r_dy1;
    assign w_d2   = {1'b0, r_dxsq} + {1'b0, r_dysq};
    assign w_x    = XY_W'(r_dx2) <<< VEC_SHIFT;
    assign w_y    = XY_W'(r_dy2) <<< VEC_SHIFT;

    always_comb begin
        n_vec.x = w_x;
        n_vec.y = w_y;
        n_vec.z = '0;
        // A vector in the left half-plane is first turned by a quarter turn.
        if (r_dx2 < 0) begin
            if (r_dy2 >= 0) begin
                n_vec.x = w_y;
                n_vec.y = -w_x;
                n_vec.z = HALF_PI_Q28;
            end else begin
                n_vec.x = -w_y;
                n_vec.y = w_x;
                n_vec.z = -HALF_PI_Q28;
            end
        end
        n_side.heading = r_hd2;
        n_side.zero    = (r_dx2 == 0) && (r_dy2 == 0);
        n_side.arrived = w_d2 <= (SQ_W + 1)'(i_stop_r2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx1  <= D_W'(i_goal_x) - D_W'(i_pose_x);
            r_dy1  <= D_W'(i_goal_y) - D_W'(i_pose_y);
            r_hd1  <= i_heading;
            r_dxsq <= w_dxsq[SQ_W-1:0];
            r_dysq <= w_dysq[SQ_W-1:0];
            r_dx2  <= r_dx1;
            r_dy2  <= r_dy1;
            r_hd2  <= r_hd1;
            r_vec  <= n_vec;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid[2];
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

### hdl/gtg_cell.sv
// One CORDIC vectoring cell: a single micro-rotation by atan(2^-STEP).
module gtg_cell import gtg_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  logic    i_valid,
    input  t_cordic i_vec,
    input  t_side   i_side,
    output logic    o_valid,
    output t_cordic o_vec,
    output t_side   o_side
);

    logic                   r_valid;
    t_cordic                r_vec;
    t_side                  r_side;

    logic signed [XY_W-1:0] w_x, w_y, w_xs, w_ys;
    logic signed [Z_W-1:0]  w_z;
    t_cordic                n_vec;

    assign w_x  = i_vec.x;
    assign w_y  = i_vec.y;
    assign w_z  = i_vec.z;
    assign w_xs = w_x >>> STEP;
    assign w_ys = w_y >>> STEP;

    // Rotate towards the x axis; the sign of y picks the direction.
    always_comb begin
        if (w_y >= 0) begin
            n_vec.x = w_x + w_ys;
            n_vec.y = w_y - w_xs;
            n_vec.z = w_z + atan_q28(STEP);
        end else begin
            n_vec.x = w_x - w_ys;
            n_vec.y = w_y + w_xs;
            n_vec.z = w_z - atan_q28(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vec  <= n_vec;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

### hdl/gtg_back.sv
// Back end: heading error with wrap, gain multiply, rounding, saturation and result register.
module gtg_back import gtg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_cordic            i_vec,
    input  t_side              i_side,
    input  logic [15:0]        i_gain,
    input  logic [SPEED_W-1:0] i_cruise,
    output logic               o_adv,
    gtg_cmd_if.source          o_cmd
);

    localparam int BEAR_W = 17;
    localparam int ERR_W  = 18;
    localparam int PROD_W = ERR_W + 17;
    localparam logic signed [ERR_W-1:0] BOUND = ERR_W'(BOUND_Q12);
    localparam logic signed [ERR_W-1:0] WRAP  = ERR_W'(WRAP_Q12);
    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    logic                      r_valid_err, r_valid_prod, r_valid_out;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_arr_err, r_arr_prod;
    logic [SPEED_W-1:0]        r_speed;
    logic signed [RATE_W-1:0]  r_rate;
    logic                      r_arrived;

    logic signed [Z_W:0]       w_zr;
    logic signed [BEAR_W-1:0]  w_bear;
    logic signed [ERR_W-1:0]   w_err0, w_err1, n_err;
    logic signed [PROD_W:0]    w_rnd;
    logic signed [PROD_W-16:0] w_rate;
    logic signed [RATE_W-1:0]  n_rate;

    assign o_adv = !r_valid_out || o_cmd.ready;

    // Bearing rounded from Q3.28 to Q4.12; the heading error is then wrapped once.
    always_comb begin
        w_zr   = {i_vec.z[Z_W-1], i_vec.z} + (Z_W + 1)'(32768);
        w_bear = i_side.zero ? '0 : w_zr[Z_W:16];
        w_err0 = ERR_W'(w_bear) - ERR_W'(i_side.heading);
        w_err1 = (w_err0 >= BOUND) ? w_err0 - WRAP : w_err0;
        n_err  = (w_err1 <= -BOUND) ? w_err1 + WRAP : w_err1;
    end

    always_comb begin
        w_rnd  = {r_prod[PROD_W-1], r_prod} + (PROD_W + 1)'(32768);
        w_rate = w_rnd[PROD_W:16];
        if (w_rate > (PROD_W - 15)'(RATE_MAX)) begin
            n_rate = RATE_MAX;
        end else if (w_rate < (PROD_W - 15)'(RATE_MIN)) begin
            n_rate = RATE_MIN;
        end else begin
            n_rate = w_rate[RATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_err  <= 1'b0;
            r_valid_prod <= 1'b0;
            r_valid_out  <= 1'b0;
        end else if (o_adv) begin
            r_valid_err  <= i_valid;
            r_valid_prod <= r_valid_err;
            r_valid_out  <= r_valid_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_err      <= n_err;
            r_arr_err  <= i_side.arrived;
            r_prod     <= $signed({1'b0, i_gain}) * r_err;
            r_arr_prod <= r_arr_err;
            r_arrived  <= r_arr_prod;
            r_speed    <= r_arr_prod ? '0 : i_cruise;
            r_rate     <= r_arr_prod ? '0 : n_rate;
        end
    end

    assign o_cmd.valid        = r_valid_out;
    assign o_cmd.linear_speed = r_speed;
    assign o_cmd.angular_rate = r_rate;
    assign o_cmd.arrived      = r_arrived;

endmodule

### hdl/go_to_goal_heading_controller_core.sv
// Top level of the go-to-goal heading controller: configuration registers and cell chain.
//
// Usage: poses (x, y, heading) arrive as requests on i_pose; each gives exactly one
// command request (linear speed, angular rate, arrived) on o_cmd, in order.
// Goal, gain, stop radius and cruise speed are written through i_cfg, which is always
// ready; write them only while no pose is in flight.
// From pose to command the pipeline has three front-end stages (offset, squares, arrival
// test and pre-rotation), one register per CORDIC cell and three back-end stages
// (error wrap, gain multiply, rounding into the result register).
// Throughput is one pose per cycle while o_cmd is not stalled; the chain of rotation cells
// sets it, every cell handling a different pose in each cycle.
// When o_cmd is stalled with a result held, the whole pipeline freezes and i_pose.ready
// drops until the result is taken; nothing is lost or repeated.
// Reset (i_rst_n low at a clock edge) empties the pipeline and restores the default
// goal (1.0, 1.0), gain 1.5, stop radius 51 and cruise speed 1.0.
module go_to_goal_heading_controller_core import gtg_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gtg_cfg_if.sink   i_cfg,
    gtg_pose_if.sink  i_pose,
    gtg_cmd_if.source o_cmd
);

    localparam int N_CELLS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    logic signed [POS_W-1:0] r_goal_x, r_goal_y;
    logic [15:0]             r_gain, r_stop_radius;
    logic [SPEED_W-1:0]      r_cruise;
    logic [2*POS_W-1:0]      r_stop_r2;

    logic                    w_adv;
    logic                    w_valid [0:N_CELLS];
    t_cordic                 w_vec   [0:N_CELLS];
    t_side                   w_side  [0:N_CELLS];

    assign i_cfg.ready  = 1'b1;
    assign i_pose.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x      <= 16'sd256;
            r_goal_y      <= 16'sd256;
            r_gain        <= 16'd6144;
            r_stop_radius <= 16'd51;
            r_cruise      <= 15'd256;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_GOAL_X:       r_goal_x      <= i_cfg.data;
                REG_GOAL_Y:       r_goal_y      <= i_cfg.data;
                REG_STEER_GAIN:   r_gain        <= i_cfg.data;
                REG_STOP_RADIUS:  r_stop_radius <= i_cfg.data;
                REG_CRUISE_SPEED: r_cruise      <= i_cfg.data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // The squared radius is registered and follows the stop radius register in the next cycle.
    always_ff @(posedge i_clk) begin
        r_stop_r2 <= r_stop_radius * r_stop_radius;
    end

    gtg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (i_pose.valid),
        .i_pose_x  (i_pose.pose_x),
        .i_pose_y  (i_pose.pose_y),
        .i_heading (i_pose.heading),
        .i_goal_x  (r_goal_x),
        .i_goal_y  (r_goal_y),
        .i_stop_r2 (r_stop_r2),
        .o_valid   (w_valid[0]),
        .o_vec     (w_vec[0]),
        .o_side    (w_side[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        gtg_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g]),
            .i_vec   (w_vec[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_vec   (w_vec[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    gtg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[N_CELLS]),
        .i_vec    (w_vec[N_CELLS]),
        .i_side   (w_side[N_CELLS]),
        .i_gain   (r_gain),
        .i_cruise (r_cruise),
        .o_adv    (w_adv),
        .o_cmd    (o_cmd)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid && !o_cmd.ready |-> !i_pose.ready)
        else $error("pose request taken while a command is stalled");

    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid && o_cmd.arrived |-> o_cmd.linear_speed == '0 && o_cmd.angular_rate == '0)
        else $error("arrived command carries a non-zero speed");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid && !o_cmd.ready |=> o_cmd.valid && $stable(o_cmd.angular_rate))
        else $error("stalled command changed or vanished");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_cmd.valid)
        else $error("command valid straight after reset");

endmodule

### bench/testbench.sv
// Self-checking bench for the go-to-goal heading controller core.
`timescale 1ns / 1ps

module testbench;
    import gtg_pkg::*;

    localparam int  STEPS            = 16;
    localparam int  LATENCY          = STEPS + 6;
    localparam int  CLK_PERIOD       = 4;
    localparam int  RESET_CYCLES     = 8;
    localparam int  RANDOM_PER_PHASE = 320;
    localparam int  N_PHASES         = 6;
    localparam int  WATCHDOG_LIMIT   = 4000;
    localparam int  HOLD_AFTER       = 400;
    localparam int  HOLD_CYCLES      = 300;
    localparam int  MAX_REPORTS      = 100;
    localparam int  FIRST_UNMAPPED   = int'(REG_CRUISE_SPEED) + 1;
    localparam int  LAST_UNMAPPED    = 2 ** CFG_IDX_W - 1;
    localparam int  HEAD_LIMIT       = 12868;
    localparam int  ERR_BOUND        = 12861;
    localparam int  ERR_WRAP         = 2 * ERR_BOUND;
    localparam int  ATAN_LEN         = 24;
    localparam longint QUARTER_TURN  = 64'sd421657428;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} t_stall;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] heading;
    } t_pose;

    typedef struct packed {
        logic [SPEED_W-1:0]       linear_speed;
        logic signed [RATE_W-1:0] angular_rate;
        logic                     arrived;
    } t_command;

    class heading_scoreboard;
        longint   atan_tab[ATAN_LEN];
        longint   target_x;
        longint   target_y;
        longint   gain;
        longint   radius;
        longint   cruise;
        t_command expected_commands[$];
        int       errors;
        int       n_checked;

        function new();
            atan_tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                         4193963, 2097109, 1048571, 524287, 262144, 131072,
                         65536, 32768, 16384, 8192, 4096, 2048,
                         1024, 512, 256, 128, 64, 32};
            target_x  = 256;
            target_y  = 256;
            gain      = 6144;
            radius    = 51;
            cruise    = 256;
            errors    = 0;
            n_checked = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t mismatch: %s", $time, msg);
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_GOAL_X:       target_x = longint'($signed(val));
                REG_GOAL_Y:       target_y = longint'($signed(val));
                REG_STEER_GAIN:   gain     = longint'(val);
                REG_STOP_RADIUS:  radius   = longint'(val);
                REG_CRUISE_SPEED: cruise   = longint'(val[SPEED_W-1:0]);
                default: ;
            endcase
        endfunction

        // Bearing of (dx, dy) in Q4.12, vectors scaled by 2^14 and angles kept in Q3.28.
        function longint bearing_to_target(longint dx, longint dy);
            longint x;
            longint y;
            longint z;
            longint t;
            longint xs;
            longint ys;
            int     n;
            if (dx == 0 && dy == 0) begin
                return 0;
            end
            n = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
            x = dx * 16384;
            y = dy * 16384;
            z = 0;
            // The rotation only converges in the right half-plane, so turn by a quarter first.
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = QUARTER_TURN;
                end else begin
                    x = -y;
                    y = t;
                    z = -QUARTER_TURN;
                end
            end
            for (int i = 0; i < n; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_tab[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_tab[i];
                end
            end
            return (z + 32768) >>> 16;
        endfunction

        function t_command predict_command(t_pose p);
            t_command c;
            longint   px;
            longint   py;
            longint   hd;
            longint   dx;
            longint   dy;
            longint   err;
            longint   rate;
            px  = p.x;
            py  = p.y;
            hd  = p.heading;
            dx  = target_x - px;
            dy  = target_y - py;
            err = bearing_to_target(dx, dy) - hd;
            if (err >= ERR_BOUND) begin
                err = err - ERR_WRAP;
            end
            if (err <= -ERR_BOUND) begin
                err = err + ERR_WRAP;
            end
            if (dx * dx + dy * dy <= radius * radius) begin
                c.linear_speed = '0;
                c.angular_rate = '0;
                c.arrived      = 1'b1;
            end else begin
                rate = (gain * err + 32768) >>> 16;
                if (rate > 32767) begin
                    rate = 32767;
                end
                if (rate < -32768) begin
                    rate = -32768;
                end
                c.linear_speed = SPEED_W'(cruise);
                c.angular_rate = RATE_W'(rate);
                c.arrived      = 1'b0;
            end
            return c;
        endfunction

        function void note_pose(t_pose p);
            expected_commands.push_back(predict_command(p));
        endfunction

        function void check_command(t_command got);
            t_command want;
            if (expected_commands.size() == 0) begin
                report($sformatf("command with no pose outstanding: speed %0d rate %0d arrived %0b",
                                 got.linear_speed, got.angular_rate, got.arrived));
                return;
            end
            want = expected_commands.pop_front();
            n_checked++;
            if (got.linear_speed !== want.linear_speed) begin
                report($sformatf("linear_speed got %0d, want %0d",
                                 got.linear_speed, want.linear_speed));
            end
            if (got.angular_rate !== want.angular_rate) begin
                report($sformatf("angular_rate got %0d, want %0d",
                                 got.angular_rate, want.angular_rate));
            end
            if (got.arrived !== want.arrived) begin
                report($sformatf("arrived got %0b, want %0b", got.arrived, want.arrived));
            end
        endfunction

        function void report_missing();
            if (expected_commands.size() != 0) begin
                report($sformatf("%0d command(s) never arrived", expected_commands.size()));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    gtg_cfg_if  cfg_ch();
    gtg_pose_if pose_ch();
    gtg_cmd_if  cmd_ch();

    heading_scoreboard sb;
    t_pose             pose_plan[$];
    int                quiet_cycles = 0;

    go_to_goal_heading_controller_core #(
        .CORDIC_STEPS(STEPS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_pose (pose_ch.sink),
        .o_cmd  (cmd_ch.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watches all three channels, feeds the scoreboard and guards against a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                sb.check_command('{cmd_ch.linear_speed, cmd_ch.angular_rate, cmd_ch.arrived});
            end
            if (pose_ch.valid && pose_ch.ready) begin
                sb.note_pose('{pose_ch.pose_x, pose_ch.pose_y, pose_ch.heading});
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (pose_ch.valid && pose_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Command receiver: stalls in changing patterns, plus one long hold-off to back up the pipe.
    initial begin : receiver
        t_stall mode;
        int     mode_left;
        int     cyc;
        bit     held;
        cmd_ch.ready <= 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        cyc       = 0;
        held      = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (!held && sb.n_checked >= HOLD_AFTER) begin
                held = 1'b1;
                cmd_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  cmd_ch.ready <= 1'b1;
                    STALL_COIN:  cmd_ch.ready <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: cmd_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:     cmd_ch.ready <= (cyc % 8 != 0);
                endcase
            end
        end
    end

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return POS_W'(v);
    endfunction

    function automatic void plan_pose(int x, int y, int h);
        t_pose p;
        p.x       = POS_W'(x);
        p.y       = POS_W'(y);
        p.heading = HEAD_W'(h);
        pose_plan.push_back(p);
    endfunction

    // Mostly scattered poses, with a share close to the goal so that arrivals keep turning up.
    function automatic t_pose random_pose();
        t_pose p;
        int    pick;
        int    reach;
        pick = $urandom_range(0, 15);
        if (pick < 4) begin
            reach = (sb.radius + 8 > 4000) ? 4000 : int'(sb.radius + 8);
            p.x = clamp_pos(sb.target_x + longint'($urandom_range(0, 2 * reach)) - reach);
            p.y = clamp_pos(sb.target_y + longint'($urandom_range(0, 2 * reach)) - reach);
        end else if (pick == 4) begin
            // Straight along one axis from the goal.
            p.x = POS_W'($urandom);
            p.y = POS_W'($urandom);
            if ($urandom_range(0, 1) == 1) begin
                p.x = POS_W'(sb.target_x);
            end else begin
                p.y = POS_W'(sb.target_y);
            end
        end else begin
            p.x = POS_W'($urandom);
            p.y = POS_W'($urandom);
        end
        if ($urandom_range(0, 3) == 0) begin
            p.heading = HEAD_W'($urandom);
        end else begin
            p.heading = HEAD_W'(int'($urandom_range(0, 2 * HEAD_LIMIT)) - HEAD_LIMIT);
        end
        return p;
    endfunction

    task automatic send_poses();
        t_pose p;
        int    burst_left;
        int    gap;
        burst_left = $urandom_range(1, 40);
        while (pose_plan.size() > 0) begin
            p = pose_plan.pop_front();
            pose_ch.valid   <= 1'b1;
            pose_ch.pose_x  <= p.x;
            pose_ch.pose_y  <= p.y;
            pose_ch.heading <= p.heading;
            @(posedge i_clk);
            while (!pose_ch.ready) @(posedge i_clk);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap        = $urandom_range(0, 12);
                if (gap > 0) begin
                    pose_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        pose_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int gx, int gy, int steer, int stop, int speed);
        write_reg(REG_GOAL_X, CFG_DATA_W'(gx));
        write_reg(REG_GOAL_Y, CFG_DATA_W'(gy));
        write_reg(REG_STEER_GAIN, CFG_DATA_W'(steer));
        write_reg(REG_STOP_RADIUS, CFG_DATA_W'(stop));
        write_reg(REG_CRUISE_SPEED, CFG_DATA_W'(speed));
    endtask

    task automatic wait_drained();
        while (sb.expected_commands.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        pose_ch.valid   <= 1'b0;
        pose_ch.pose_x  <= '0;
        pose_ch.pose_y  <= '0;
        pose_ch.heading <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    // Reset goal (1.0, 1.0), stop radius 51.
                    plan_pose(256, 256, 0);
                    plan_pose(256, 256, HEAD_LIMIT);
                    plan_pose(307, 256, 0);
                    plan_pose(308, 256, 0);
                    plan_pose(356, 156, HEAD_LIMIT);
                    plan_pose(356, 356, -HEAD_LIMIT);
                    plan_pose(-32768, -32768, -HEAD_LIMIT);
                    plan_pose(32767, 32767, HEAD_LIMIT);
                    plan_pose(-32768, 32767, -16384);
                    plan_pose(32767, -32768, 16383);
                    plan_pose(256, -32768, 0);
                    plan_pose(256, 32767, 0);
                    plan_pose(0, 256, HEAD_LIMIT);
                    plan_pose(0, 256, -HEAD_LIMIT);
                    plan_pose(0, 256, -ERR_BOUND);
                    plan_pose(0, 256, ERR_BOUND);
                end
                1: begin
                    configure(-32768, 32767, 65535, 65535, 32767);
                    // A write to an unmapped index must leave every register alone.
                    write_reg(CFG_IDX_W'($urandom_range(FIRST_UNMAPPED, LAST_UNMAPPED)),
                              CFG_DATA_W'($urandom));
                    plan_pose(32767, -32768, -HEAD_LIMIT);
                    plan_pose(32767, -32768, HEAD_LIMIT);
                    plan_pose(32767, 32767, 0);
                    plan_pose(-32768, -32768, 16383);
                end
                2: begin
                    configure(32767, -32768, 0, 0, 0);
                    plan_pose(32767, -32768, 0);
                    plan_pose(32766, -32768, 5000);
                end
                4: configure(0, 0, 4096, 1000, 12345);
                default: configure(int'($urandom_range(0, 65535)) - 32768,
                                   int'($urandom_range(0, 65535)) - 32768,
                                   $urandom_range(0, 65535), $urandom_range(0, 4096),
                                   $urandom_range(0, 65535));
            endcase
            repeat (RANDOM_PER_PHASE) pose_plan.push_back(random_pose());
            send_poses();
            wait_drained();
        end

        sb.report_missing();
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
